>>> rtl/core/acms_pkg.sv
package acms_pkg;

    // Format codes carried on format_code
    localparam logic [2:0] FMT_UNKNOWN = 3'd0;
    localparam logic [2:0] FMT_WAV     = 3'd1;
    localparam logic [2:0] FMT_FLAC    = 3'd2;
    localparam logic [2:0] FMT_OGG     = 3'd3;
    localparam logic [2:0] FMT_OPUS    = 3'd4;
    localparam logic [2:0] FMT_MP3     = 3'd5;

    // Header store and search window geometry
    localparam int unsigned HDR_LEN = 12;
    localparam int unsigned HDR_AW  = 4;
    localparam int unsigned WIN_LEN = 7;

    // Magic tags, first file byte in the most significant position
    localparam logic [31:0] TAG_RIFF  = "RIFF";
    localparam logic [31:0] TAG_WAVE  = "WAVE";
    localparam logic [31:0] TAG_FLAC  = "fLaC";
    localparam logic [31:0] TAG_OGGS  = "OggS";
    localparam logic [23:0] TAG_ID3   = "ID3";
    localparam logic [55:0] TAG_OPUSH = "OpusHea";
    localparam logic [7:0]  TAG_OPUST = "d";
    localparam logic [7:0]  SYNC_BYTE = 8'hFF;
    localparam logic [7:0]  SYNC_MASK = 8'hE0;

    typedef logic [7:0] byte_t;

endpackage

>>> rtl/core/audio_container_magic_sniffer_top.sv
// Audio container magic sniffer.
// Input channel (in_valid / in_stall): one header byte per transfer on
// data_byte, in file order, with final_byte high on the last byte of the
// buffer. Only the first SNIFF_BYTES bytes are examined; later bytes are
// absorbed without effect, but a final mark on them still yields a result.
// Output channel (out_valid / out_stall): one transfer of format_code per
// final byte (0 unknown, 1 wav, 2 flac, 3 ogg, 4 opus, 5 mp3).
// Latency: the code is shown the cycle after the final byte is taken.
// Throughput: one byte per cycle while in_stall is low; the work per byte is
// a handful of byte compares, a shift of the 7-byte window and at most one
// store write, all combinational ahead of the result register.
// The result register holds one code; while it is full and out_stall is
// high, in_stall is raised and the held code stays steady. When the code is
// taken the next byte may be transferred in the same cycle.
// Reset (rst_n low, asynchronous) empties the result register and clears
// the byte count, header store, window and OpusHead flag; the same
// clearing happens after every final byte, so each buffer starts afresh.
module audio_container_magic_sniffer_top #(
    parameter int unsigned SNIFF_BYTES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] format_code
);
    import acms_pkg::*;

    localparam int unsigned CW = $clog2(SNIFF_BYTES + 1);

    logic [CW-1:0] byte_count_reg, byte_count_next, count_upd;
    byte_t         header_store_reg [HDR_LEN];
    byte_t         header_store_next[HDR_LEN];
    byte_t         header_upd       [HDR_LEN];
    byte_t         search_window_reg [WIN_LEN];
    byte_t         search_window_next[WIN_LEN];
    byte_t         window_upd        [WIN_LEN];
    logic          opus_seen_reg, opus_seen_next, opus_upd;
    logic          out_valid_reg, out_valid_next;
    logic [2:0]    format_reg, format_next;

    logic          in_acc, out_acc, examine;
    logic [2:0]    fmt_class;
    logic [31:0]   head0, head8;

    assign out_acc  = out_valid_reg && !out_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign in_acc   = in_valid && !in_stall;
    assign examine  = byte_count_reg < CW'(SNIFF_BYTES);

    // Absorb the byte into the sniffing state
    always_comb
    begin
        count_upd  = byte_count_reg;
        header_upd = header_store_reg;
        window_upd = search_window_reg;
        opus_upd   = opus_seen_reg;
        if (examine)
        begin
            if (byte_count_reg < CW'(HDR_LEN))
            begin
                header_upd[byte_count_reg[HDR_AW-1:0]] = data_byte;
            end
            if (byte_count_reg >= CW'(WIN_LEN)
                && {search_window_reg[0], search_window_reg[1], search_window_reg[2],
                    search_window_reg[3], search_window_reg[4], search_window_reg[5],
                    search_window_reg[6]} == TAG_OPUSH
                && data_byte == TAG_OPUST)
            begin
                opus_upd = 1'b1;
            end
            for (int i = 0; i < WIN_LEN - 1; i++)
            begin
                window_upd[i] = search_window_reg[i + 1];
            end
            window_upd[WIN_LEN - 1] = data_byte;
            count_upd = byte_count_reg + CW'(1);
        end
    end

    // Classification on the state including the current byte
    assign head0 = {header_upd[0], header_upd[1], header_upd[2], header_upd[3]};
    assign head8 = {header_upd[8], header_upd[9], header_upd[10], header_upd[11]};

    always_comb
    begin
        priority if (count_upd >= CW'(12) && head0 == TAG_RIFF && head8 == TAG_WAVE)
            fmt_class = FMT_WAV;
        else if (count_upd >= CW'(4) && head0 == TAG_FLAC)
            fmt_class = FMT_FLAC;
        else if (count_upd >= CW'(4) && head0 == TAG_OGGS)
            fmt_class = opus_upd ? FMT_OPUS : FMT_OGG;
        else if (count_upd >= CW'(3) && head0[31:8] == TAG_ID3)
            fmt_class = FMT_MP3;
        else if (count_upd >= CW'(2) && header_upd[0] == SYNC_BYTE
                 && (header_upd[1] & SYNC_MASK) == SYNC_MASK)
            fmt_class = FMT_MP3;
        else
            fmt_class = FMT_UNKNOWN;
    end

    // Next state: hold, absorb, or clear after the final byte
    always_comb
    begin
        byte_count_next    = byte_count_reg;
        header_store_next  = header_store_reg;
        search_window_next = search_window_reg;
        opus_seen_next     = opus_seen_reg;
        out_valid_next     = out_valid_reg && !out_acc;
        format_next        = format_reg;
        if (in_acc)
        begin
            if (final_byte)
            begin
                byte_count_next = '0;
                for (int i = 0; i < HDR_LEN; i++)
                    header_store_next[i] = '0;
                for (int i = 0; i < WIN_LEN; i++)
                    search_window_next[i] = '0;
                opus_seen_next = 1'b0;
                out_valid_next = 1'b1;
                format_next    = fmt_class;
            end
            else
            begin
                byte_count_next    = count_upd;
                header_store_next  = header_upd;
                search_window_next = window_upd;
                opus_seen_next     = opus_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            opus_seen_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < HDR_LEN; i++)
                header_store_reg[i] <= '0;
            for (int i = 0; i < WIN_LEN; i++)
                search_window_reg[i] <= '0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            opus_seen_reg     <= opus_seen_next;
            out_valid_reg     <= out_valid_next;
            header_store_reg  <= header_store_next;
            search_window_reg <= search_window_next;
        end
    end

    always_ff @(posedge clk)
    begin
        format_reg <= format_next;
    end

    assign out_valid   = out_valid_reg;
    assign format_code = format_reg;

`ifndef SYNTHESIS
    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && final_byte |=> out_valid_reg)
        else $error("final byte gave no result");

    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && final_byte |=> byte_count_reg == '0 && !opus_seen_reg)
        else $error("state not cleared after final byte");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(SNIFF_BYTES))
        else $error("byte count beyond window");

    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && !final_byte |=> byte_count_reg != '0)
        else $error("byte count did not advance");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> format_reg <= FMT_MP3)
        else $error("format code out of range");
`endif

endmodule
